// ===== hw/rtl/bqr_pkg.sv =====
`timescale 1ns / 1ps

package bqr_pkg;

    // Default sizes
    localparam int NARROW_GROUP_DEF   = 32;
    localparam int MAX_WIDE_GROUP_DEF = 32;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WGS  = 1'b1;

    // Mode register bits
    localparam int MODE_OFFSET_BIT = 0;
    localparam int MODE_WIDE_BIT   = 1;

    // Result kinds
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    // Single-precision constants
    localparam logic [31:0] FP_ONE     = 32'h3F80_0000;
    localparam logic [31:0] FP_SEVEN   = 32'h40E0_0000;
    localparam logic [31:0] FP_FIFTEEN = 32'h4170_0000;
    localparam logic [31:0] FP_D127    = 32'h42FE_0000;
    localparam logic [31:0] FP_D255    = 32'h437F_0000;
    localparam logic [31:0] FP_QNAN    = 32'hFFC0_0000;
    localparam logic [31:0] FP_QBIT    = 32'h0040_0000;

    // Request / response between the sequencer and a float unit
    typedef struct packed {
        logic        start;
        logic [31:0] a;
        logic [31:0] b;
    } t_fp_req;

    typedef struct packed {
        logic        done;
        logic [31:0] res;
    } t_fp_rsp;

    // IEEE less-than: false on NaN, +0 == -0
    function automatic logic flt_lt(logic [31:0] a, logic [31:0] b);
        logic a_nan;
        logic b_nan;
        logic res;
        begin
            a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
            b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
            if (a_nan || b_nan) begin
                res = 1'b0;
            end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
                res = 1'b0;
            end else if (a[31] != b[31]) begin
                res = a[31];
            end else if (!a[31]) begin
                res = a[30:0] < b[30:0];
            end else begin
                res = a[30:0] > b[30:0];
            end
            return res;
        end
    endfunction

    // Round half away from zero, clamp, and map to the stored code
    function automatic logic [7:0] quant_code(logic [31:0] t, logic wide, logic sym);
        logic [7:0]         ex;
        logic [23:0]        m24;
        logic [7:0]         sh;
        logic [23:0]        r;
        logic [8:0]         mag;
        logic signed [10:0] v;
        logic signed [10:0] lo;
        logic signed [10:0] hi;
        logic signed [10:0] vp;
        logic [7:0]         code;
        begin
            ex  = t[30:23];
            m24 = {ex != 8'd0, t[22:0]};
            lo  = sym ? (wide ? -11'sd127 : -11'sd8) : 11'sd0;
            hi  = wide ? (sym ? 11'sd127 : 11'sd255) : (sym ? 11'sd7 : 11'sd15);
            sh  = 8'd150 - ex;
            r   = 24'd0;
            mag = 9'd0;
            v   = 11'sd0;
            if ((ex == 8'hFF) && (t[22:0] != 23'd0)) begin
                v = 11'sd0;
            end else if (ex >= 8'd135) begin
                v = t[31] ? lo : hi;
            end else begin
                if (sh <= 8'd25) begin
                    r = m24 >> (sh - 8'd1);
                end
                mag = 9'((r + 24'd1) >> 1);
                v   = t[31] ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
                if (v > hi) begin
                    v = hi;
                end
                if (v < lo) begin
                    v = lo;
                end
            end
            vp = v + 11'sd8;
            if (sym && !wide) begin
                code = {4'd0, vp[3:0]};
            end else begin
                code = v[7:0];
            end
            return code;
        end
    endfunction

endpackage

// ===== hw/rtl/block_quantizer_rtn_unit.sv =====
`timescale 1ns / 1ps

// Round-to-nearest block quantizer, 4-bit and 8-bit.
// Input channel (i_in_valid / o_in_stall): one single-precision weight per
// transfer, i_end_of_tensor closes a partial block. A weight that does not
// close its block leaves the input open. Output channel (o_out_valid /
// i_out_stall): per block one header (kind 0, scale, zero point), then the
// data bytes, the final one with o_last set. Configuration (i_cfg_valid /
// o_cfg_ready): index 0 mode, index 1 wide group size; a write drops the
// open block.
// On close the block is drained from the weight store: the scale takes one
// float divide (plus a subtract in offset modes), then each element takes a
// store read, an optional subtract and a divide, one element at a time. The
// divider, which first normalizes subnormal operands, sets the pace; each
// data byte then waits for a free output register before it is emitted.
// The input stalls while a block drains and reopens once the last byte sits
// in the output register.
// Reset clears mode to symmetric 4-bit, wide group size to 32 and empties
// the open block. A stalled output holds its transfer; the drain waits.
module block_quantizer_rtn_unit #(
    parameter int NARROW_GROUP   = bqr_pkg::NARROW_GROUP_DEF,
    parameter int MAX_WIDE_GROUP = bqr_pkg::MAX_WIDE_GROUP_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [31:0]                  i_value_bits,
    input  logic                         i_end_of_tensor,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_kind,
    output logic [31:0]                  o_scale_bits,
    output logic [31:0]                  o_zero_point_bits,
    output logic [7:0]                   o_data_byte,
    output logic                         o_last,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [bqr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [5:0]                   i_cfg_data
);
    import bqr_pkg::*;

    localparam int DEPTH    = (NARROW_GROUP > MAX_WIDE_GROUP) ? NARROW_GROUP : MAX_WIDE_GROUP;
    localparam int AW       = $clog2(DEPTH);
    localparam int FW       = $clog2(DEPTH + 1);
    localparam int NB       = (NARROW_GROUP + 1) / 2;
    localparam int ELEM_MAX = (2 * NB > DEPTH) ? 2 * NB : DEPTH;
    localparam int EW       = $clog2(ELEM_MAX + 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SC_START = 4'd1;
    localparam logic [3:0] S_SC_SUB   = 4'd2;
    localparam logic [3:0] S_SC_DIV   = 4'd3;
    localparam logic [3:0] S_HDR      = 4'd4;
    localparam logic [3:0] S_RD       = 4'd5;
    localparam logic [3:0] S_RDW      = 4'd6;
    localparam logic [3:0] S_EL_SUB   = 4'd7;
    localparam logic [3:0] S_EL_DIV   = 4'd8;
    localparam logic [3:0] S_EMIT     = 4'd9;

    logic [3:0]    r_state;
    logic [1:0]    r_mode;
    logic [5:0]    r_wgs;
    logic [FW-1:0] r_fill;
    logic [31:0]   r_max, r_min;
    logic [FW-1:0] r_count;
    logic [EW-1:0] r_elem;
    logic [31:0]   r_scale;
    logic [3:0]    r_c0;
    logic [7:0]    r_obyte;
    logic          r_olast;
    logic [31:0]   r_rd_data;
    logic [31:0]   r_store [DEPTH];

    logic          r_out_valid, r_kind, r_last;
    logic [31:0]   r_oscale, r_ozp;
    logic [7:0]    r_odata;

    t_fp_req sub_req, div_req;
    t_fp_rsp sub_rsp, div_rsp;

    logic          sym, wide, in_acc, closes, out_free, missing, byte_last, wide_last;
    logic [FW-1:0] group, fill_inc;
    logic [5:0]    wgs_c;
    logic [31:0]   abs_x, m0, n_max, n_min, div_k;
    logic [7:0]    code;
    logic [3:0]    pad;

    assign sym        = !r_mode[MODE_OFFSET_BIT];
    assign wide       = r_mode[MODE_WIDE_BIT];
    assign o_in_stall = r_state != S_IDLE;
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign pad        = sym ? 4'h8 : 4'h0;
    assign div_k      = wide ? (sym ? FP_D127 : FP_D255) : (sym ? FP_SEVEN : FP_FIFTEEN);
    assign code       = quant_code(div_rsp.res, wide, sym);
    assign missing    = !wide && (r_elem >= EW'(r_count));
    assign byte_last  = (r_elem >> 1) == EW'(NB - 1);
    assign wide_last  = (r_elem + 1'b1) == EW'(r_count);

    // Block size and close condition
    always_comb begin
        if (r_wgs == 6'd0) begin
            wgs_c = 6'd1;
        end else if ({1'b0, r_wgs} > 7'(MAX_WIDE_GROUP)) begin
            wgs_c = 6'(MAX_WIDE_GROUP);
        end else begin
            wgs_c = r_wgs;
        end
        group    = wide ? FW'(wgs_c) : FW'(NARROW_GROUP);
        fill_inc = r_fill + 1'b1;
        closes   = i_end_of_tensor || (fill_inc >= group);
    end

    // Running max / min
    always_comb begin
        abs_x = {1'b0, i_value_bits[30:0]};
        m0    = (r_fill == '0) ? 32'd0 : r_max;
        n_max = r_max;
        n_min = r_min;
        if (sym) begin
            n_max = flt_lt(m0, abs_x) ? abs_x : m0;
        end else if (r_fill == '0) begin
            n_max = i_value_bits;
            n_min = i_value_bits;
        end else begin
            n_min = flt_lt(i_value_bits, r_min) ? i_value_bits : r_min;
            n_max = flt_lt(r_max, i_value_bits) ? i_value_bits : r_max;
        end
    end

    // Float unit requests
    always_comb begin
        sub_req = '0;
        div_req = '0;
        case (r_state)
            S_SC_START: begin
                if (sym) begin
                    div_req = '{start: 1'b1, a: r_max, b: div_k};
                end else begin
                    sub_req = '{start: 1'b1, a: r_max, b: r_min};
                end
            end
            S_SC_SUB: begin
                if (sub_rsp.done) begin
                    div_req = '{start: 1'b1, a: sub_rsp.res, b: div_k};
                end
            end
            S_RDW: begin
                if (sym) begin
                    div_req = '{start: 1'b1, a: r_rd_data, b: r_scale};
                end else begin
                    sub_req = '{start: 1'b1, a: r_rd_data, b: r_min};
                end
            end
            S_EL_SUB: begin
                if (sub_rsp.done) begin
                    div_req = '{start: 1'b1, a: sub_rsp.res, b: r_scale};
                end
            end
            default: ;
        endcase
    end

    bqr_fsub u_fsub (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sub_req),
        .o_rsp   (sub_rsp)
    );

    bqr_fdiv u_fdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Weight store: written on input transfers, read while draining
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_store[r_fill[AW-1:0]] <= i_value_bits;
        end
        if ((r_state == S_RD) && !missing) begin
            r_rd_data <= r_store[r_elem[AW-1:0]];
        end
    end

    // Sequencer, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= 2'd0;
            r_wgs       <= 6'd32;
            r_fill      <= '0;
            r_max       <= 32'd0;
            r_min       <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_MODE) begin
                    r_mode <= i_cfg_data[1:0];
                end else begin
                    r_wgs <= i_cfg_data;
                end
                r_fill <= '0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_max <= n_max;
                        r_min <= n_min;
                        if (closes) begin
                            r_count <= fill_inc;
                            r_fill  <= '0;
                            r_state <= S_SC_START;
                        end else begin
                            r_fill <= fill_inc;
                        end
                    end
                end
                S_SC_START: begin
                    r_state <= sym ? S_SC_DIV : S_SC_SUB;
                end
                S_SC_SUB: begin
                    if (sub_rsp.done) begin
                        r_state <= S_SC_DIV;
                    end
                end
                S_SC_DIV: begin
                    if (div_rsp.done) begin
                        r_scale <= (div_rsp.res[30:0] == 31'd0) ? FP_ONE : div_rsp.res;
                        r_state <= S_HDR;
                    end
                end
                S_HDR: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_kind      <= KIND_HEADER;
                        r_oscale    <= r_scale;
                        r_ozp       <= sym ? 32'd0 : r_min;
                        r_odata     <= 8'd0;
                        r_last      <= 1'b0;
                        r_elem      <= '0;
                        r_state     <= S_RD;
                    end
                end
                S_RD: begin
                    if (missing) begin
                        if (!r_elem[0]) begin
                            r_obyte <= 8'd0;
                            r_elem  <= r_elem + 1'b1;
                        end else begin
                            r_obyte <= {pad, r_c0};
                        end
                        r_olast <= byte_last;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_RDW;
                    end
                end
                S_RDW: begin
                    r_state <= sym ? S_EL_DIV : S_EL_SUB;
                end
                S_EL_SUB: begin
                    if (sub_rsp.done) begin
                        r_state <= S_EL_DIV;
                    end
                end
                S_EL_DIV: begin
                    if (div_rsp.done) begin
                        if (wide) begin
                            r_obyte <= code;
                            r_olast <= wide_last;
                            r_state <= S_EMIT;
                        end else if (!r_elem[0]) begin
                            r_c0    <= code[3:0];
                            r_elem  <= r_elem + 1'b1;
                            r_state <= S_RD;
                        end else begin
                            r_obyte <= {code[3:0], r_c0};
                            r_olast <= byte_last;
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_kind      <= KIND_DATA;
                        r_oscale    <= 32'd0;
                        r_ozp       <= 32'd0;
                        r_odata     <= r_obyte;
                        r_last      <= r_olast;
                        r_elem      <= r_elem + 1'b1;
                        r_state     <= r_olast ? S_IDLE : S_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_kind            = r_kind;
    assign o_scale_bits      = r_oscale;
    assign o_zero_point_bits = r_ozp;
    assign o_data_byte       = r_odata;
    assign o_last            = r_last;

endmodule

// ===== hw/rtl/bqr_fsub.sv =====
`timescale 1ns / 1ps

// Single-precision a - b, round to nearest even.
// Align in the start cycle, then normalize one bit per cycle, then round.
module bqr_fsub (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bqr_pkg::t_fp_req  i_req,
    output bqr_pkg::t_fp_rsp  o_rsp
);
    import bqr_pkg::*;

    localparam logic F_IDLE = 1'b0;
    localparam logic F_NORM = 1'b1;

    logic        r_state;
    logic        r_done;
    logic [31:0] r_res;
    logic        r_sign;
    logic [8:0]  r_exp;
    logic [27:0] r_mant;

    logic        sa, sb, a_nan, b_nan, a_inf, b_inf, a_big, special, sgn;
    logic [7:0]  ea, eb, xa, xb, xl, xs, d;
    logic [23:0] ma, mb, ml, ms;
    logic        sl, ss;
    logic [26:0] ext, shv, al;
    logic        stk;
    logic [27:0] sum;
    logic [31:0] spec_res;
    logic [7:0]  exp_f;
    logic [30:0] packed_v, rounded;
    logic        inc;

    // Unpack and align
    always_comb begin
        sa    = i_req.a[31];
        sb    = ~i_req.b[31];
        ea    = i_req.a[30:23];
        eb    = i_req.b[30:23];
        a_nan = (ea == 8'hFF) && (i_req.a[22:0] != 23'd0);
        b_nan = (eb == 8'hFF) && (i_req.b[22:0] != 23'd0);
        a_inf = (ea == 8'hFF) && (i_req.a[22:0] == 23'd0);
        b_inf = (eb == 8'hFF) && (i_req.b[22:0] == 23'd0);
        ma    = {ea != 8'd0, i_req.a[22:0]};
        mb    = {eb != 8'd0, i_req.b[22:0]};
        xa    = (ea == 8'd0) ? 8'd1 : ea;
        xb    = (eb == 8'd0) ? 8'd1 : eb;
        a_big = i_req.a[30:0] >= i_req.b[30:0];
        ml    = a_big ? ma : mb;
        ms    = a_big ? mb : ma;
        xl    = a_big ? xa : xb;
        xs    = a_big ? xb : xa;
        sl    = a_big ? sa : sb;
        ss    = a_big ? sb : sa;
        d     = xl - xs;
        ext   = {ms, 3'b000};
        if (d >= 8'd27) begin
            shv = 27'd0;
            stk = |ext;
        end else begin
            shv = ext >> d;
            stk = |(ext & ~({27{1'b1}} << d));
        end
        al = {shv[26:1], shv[0] | stk};
        if (sl == ss) begin
            sum = {1'b0, ml, 3'b000} + {1'b0, al};
        end else begin
            sum = {1'b0, ml, 3'b000} - {1'b0, al};
        end
        sgn = ((sl != ss) && (sum == 28'd0)) ? 1'b0 : sl;

        // NaN, infinity
        special  = 1'b1;
        spec_res = FP_QNAN;
        if (a_nan) begin
            spec_res = i_req.a | FP_QBIT;
        end else if (b_nan) begin
            spec_res = i_req.b | FP_QBIT;
        end else if (a_inf && b_inf) begin
            spec_res = (sa != sb) ? FP_QNAN : {sa, 8'hFF, 23'd0};
        end else if (a_inf) begin
            spec_res = i_req.a;
        end else if (b_inf) begin
            spec_res = {sb, 8'hFF, 23'd0};
        end else begin
            special = 1'b0;
        end
    end

    // Rounding of the normalized sum
    always_comb begin
        exp_f    = r_mant[26] ? r_exp[7:0] : 8'd0;
        packed_v = {exp_f, r_mant[25:3]};
        inc      = r_mant[2] & (r_mant[1] | r_mant[0] | r_mant[3]);
        rounded  = packed_v + {30'd0, inc};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                F_IDLE: begin
                    if (i_req.start) begin
                        if (special) begin
                            r_res  <= spec_res;
                            r_done <= 1'b1;
                        end else begin
                            r_sign  <= sgn;
                            r_exp   <= {1'b0, xl};
                            r_mant  <= sum;
                            r_state <= F_NORM;
                        end
                    end
                end
                F_NORM: begin
                    if (r_mant[27]) begin
                        r_mant <= {1'b0, r_mant[27:2], r_mant[1] | r_mant[0]};
                        r_exp  <= r_exp + 9'd1;
                    end else if (!r_mant[26] && (r_exp > 9'd1) && (r_mant != 28'd0)) begin
                        r_mant <= {r_mant[26:0], 1'b0};
                        r_exp  <= r_exp - 9'd1;
                    end else begin
                        r_res   <= (r_exp >= 9'd255) ? {r_sign, 8'hFF, 23'd0}
                                                     : {r_sign, rounded};
                        r_done  <= 1'b1;
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

endmodule

// ===== hw/rtl/bqr_fdiv.sv =====
`timescale 1ns / 1ps

// Single-precision a / b, round to nearest even.
// Subnormal operands are normalized one bit per cycle, then a restoring
// divider produces one quotient bit per cycle (27 steps), then D_FIN rounds.
module bqr_fdiv (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bqr_pkg::t_fp_req  i_req,
    output bqr_pkg::t_fp_rsp  o_rsp
);
    import bqr_pkg::*;

    localparam logic [2:0] D_IDLE = 3'd0;
    localparam logic [2:0] D_NA   = 3'd1;
    localparam logic [2:0] D_NB   = 3'd2;
    localparam logic [2:0] D_ITER = 3'd3;
    localparam logic [2:0] D_FIN  = 3'd4;
    localparam logic [4:0] QBITS  = 5'd27;

    logic [2:0]         r_state;
    logic               r_done;
    logic [31:0]        r_res;
    logic               r_sign;
    logic signed [9:0]  r_xa, r_xb;
    logic [23:0]        r_ma, r_mb;
    logic [24:0]        r_rem;
    logic [26:0]        r_q;
    logic [4:0]         r_cnt;

    logic [7:0]   ea, eb;
    logic         a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, s, special;
    logic [31:0]  spec_res;
    logic         ge;
    logic [24:0]  rem_sub;
    logic [26:0]  m27, dn;
    logic signed [10:0] e, sh;
    logic         remnz, stk, g, st, lsb, inc;
    logic [30:0]  packed_v;
    logic [31:0]  fin_res;

    // Special operands
    always_comb begin
        ea     = i_req.a[30:23];
        eb     = i_req.b[30:23];
        a_nan  = (ea == 8'hFF) && (i_req.a[22:0] != 23'd0);
        b_nan  = (eb == 8'hFF) && (i_req.b[22:0] != 23'd0);
        a_inf  = (ea == 8'hFF) && (i_req.a[22:0] == 23'd0);
        b_inf  = (eb == 8'hFF) && (i_req.b[22:0] == 23'd0);
        a_zero = i_req.a[30:0] == 31'd0;
        b_zero = i_req.b[30:0] == 31'd0;
        s      = i_req.a[31] ^ i_req.b[31];
        special  = 1'b1;
        spec_res = FP_QNAN;
        if (a_nan) begin
            spec_res = i_req.a | FP_QBIT;
        end else if (b_nan) begin
            spec_res = i_req.b | FP_QBIT;
        end else if ((a_inf && b_inf) || (a_zero && b_zero)) begin
            spec_res = FP_QNAN;
        end else if (a_inf || b_zero) begin
            spec_res = {s, 8'hFF, 23'd0};
        end else if (a_zero || b_inf) begin
            spec_res = {s, 31'd0};
        end else begin
            special = 1'b0;
        end
    end

    // One restoring step
    always_comb begin
        ge      = r_rem >= {1'b0, r_mb};
        rem_sub = ge ? (r_rem - {1'b0, r_mb}) : r_rem;
    end

    // Normalize, denormalize and round the quotient
    always_comb begin
        m27   = r_q[26] ? r_q : {r_q[25:0], 1'b0};
        e     = {r_xa[9], r_xa} - {r_xb[9], r_xb} + 11'sd127
                - (r_q[26] ? 11'sd0 : 11'sd1);
        remnz = r_rem != 25'd0;
        sh    = 11'sd1 - e;
        dn    = 27'd0;
        stk   = 1'b0;
        if (e > 11'sd0) begin
            packed_v = {e[7:0], m27[25:3]};
            g        = m27[2];
            st       = m27[1] | m27[0] | remnz;
            lsb      = m27[3];
        end else begin
            if (sh >= 11'sd27) begin
                dn  = 27'd0;
                stk = |m27;
            end else begin
                dn  = m27 >> sh[4:0];
                stk = |(m27 & ~({27{1'b1}} << sh[4:0]));
            end
            packed_v = {8'd0, dn[25:3]};
            g        = dn[2];
            st       = dn[1] | dn[0] | stk | remnz;
            lsb      = dn[3];
        end
        inc = g & (st | lsb);
        if (e > 11'sd254) begin
            fin_res = {r_sign, 8'hFF, 23'd0};
        end else begin
            fin_res = {r_sign, packed_v + {30'd0, inc}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_req.start) begin
                        if (special) begin
                            r_res  <= spec_res;
                            r_done <= 1'b1;
                        end else begin
                            r_sign  <= s;
                            r_ma    <= {ea != 8'd0, i_req.a[22:0]};
                            r_mb    <= {eb != 8'd0, i_req.b[22:0]};
                            r_xa    <= {2'b00, (ea == 8'd0) ? 8'd1 : ea};
                            r_xb    <= {2'b00, (eb == 8'd0) ? 8'd1 : eb};
                            r_state <= D_NA;
                        end
                    end
                end
                D_NA: begin
                    if (!r_ma[23]) begin
                        r_ma <= {r_ma[22:0], 1'b0};
                        r_xa <= r_xa - 10'sd1;
                    end else begin
                        r_state <= D_NB;
                    end
                end
                D_NB: begin
                    if (!r_mb[23]) begin
                        r_mb <= {r_mb[22:0], 1'b0};
                        r_xb <= r_xb - 10'sd1;
                    end else begin
                        r_rem   <= {1'b0, r_ma};
                        r_q     <= 27'd0;
                        r_cnt   <= QBITS;
                        r_state <= D_ITER;
                    end
                end
                D_ITER: begin
                    r_q   <= {r_q[25:0], ge};
                    r_rem <= {rem_sub[23:0], 1'b0};
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd1) begin
                        r_state <= D_FIN;
                    end
                end
                D_FIN: begin
                    r_res   <= fin_res;
                    r_done  <= 1'b1;
                    r_state <= D_IDLE;
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

endmodule
